@@ rtl/core/mm_pkg.sv @@
`default_nettype none

package mm_pkg;

   // Element width of the operands and of the result, signed Q4.12.
   localparam int DATA_W = 16;
   // Width of one size register.
   localparam int CFG_W = 4;
   // Width of the register index on the write port.
   localparam int CSR_IDX_W = 2;
   // Full-precision product of two elements.
   localparam int PROD_W = 2 * DATA_W;
   // Accumulator: product width plus headroom for up to eight terms.
   localparam int ACC_W = PROD_W + 4;

   // Register indexes of the write port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS  = 2'd0,
      CSR_INNER = 2'd1,
      CSR_COLS  = 2'd2
   } csr_idx_type;

   // Request mode: which store the element goes to.
   localparam logic MODE_LEFT  = 1'b0;
   localparam logic MODE_RIGHT = 1'b1;

   // Saturation limits at accumulator and result width.
   localparam logic signed [ACC_W-1:0] ACC_HI =
      {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_LO =
      {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] DATA_HI = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_LO = {1'b1, {(DATA_W-1){1'b0}}};

   // Control from the sequencer to the multiply-accumulate datapath.
   typedef struct packed {
      logic issue;   // Store reads of one term are issued this cycle.
      logic emit;    // The finished dot product goes to the result register.
      logic last;    // The emitted element is the final one of the matrix.
   } mac_ctl_type;

endpackage

`default_nettype wire

@@ rtl/core/mm_ram.sv @@
`default_nettype none

module mm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/mm_mac.sv @@
`default_nettype none

module mm_mac #(
   parameter int FRAC_BITS = 12
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mm_pkg::mac_ctl_type         ctl,
   input  wire logic [mm_pkg::DATA_W-1:0]   left_data,
   input  wire logic [mm_pkg::DATA_W-1:0]   right_data,
   input  wire logic                        rsp_stall,
   output logic                             rsp_valid,
   output logic signed [mm_pkg::DATA_W-1:0] rsp_product_value,
   output logic                             rsp_saturated,
   output logic                             rsp_last,
   output logic                             out_free
);

   import mm_pkg::*;

   logic                     rd_valid_ff;
   logic                     prod_valid_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] term;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic                     sat_hi;
   logic                     sat_lo;
   logic signed [DATA_W-1:0] clip_value;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic                     rsp_sat_ff;
   logic                     rsp_last_ff;

   // The result register can take a new element when it is empty or being taken.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Multiply the two store outputs; the product is registered.
   assign prod_in = $signed(left_data) * $signed(right_data);

   // Arithmetic shift truncates toward minus infinity.
   assign term = prod_ff >>> FRAC_BITS;

   // Accumulate registered products; the emit clears the sum for the next element.
   always_comb begin
      acc_in = acc_ff;
      if (ctl.emit) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + ACC_W'(term);
      end
   end

   // Clip the dot product to the result range.
   assign sat_hi = acc_ff > ACC_HI;
   assign sat_lo = acc_ff < ACC_LO;

   always_comb begin
      if (sat_hi) begin
         clip_value = DATA_HI;
      end else if (sat_lo) begin
         clip_value = DATA_LO;
      end else begin
         clip_value = acc_ff[DATA_W-1:0];
      end
   end

   // Datapath stages and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         acc_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff   <= ctl.issue;
         prod_valid_ff <= rd_valid_ff;
         acc_ff        <= acc_in;
         if (ctl.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (rd_valid_ff) begin
         prod_ff <= prod_in;
      end
      if (ctl.emit) begin
         rsp_value_ff <= clip_value;
         rsp_sat_ff   <= sat_hi || sat_lo;
         rsp_last_ff  <= ctl.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_saturated     = rsp_sat_ff;
   assign rsp_last          = rsp_last_ff;

   // A new element never overwrites one that the receiver has not taken.
   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   // A flagged result carries one of the two clip values.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |-> (rsp_value_ff == DATA_HI || rsp_value_ff == DATA_LO))
      else $error("saturated result is not a clip value");

   // The accumulator is empty when the first term of an element arrives.
   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |=> (acc_ff == '0))
      else $error("accumulator not cleared after emit");

endmodule

`default_nettype wire

@@ rtl/core/mm_seq.sv @@
`default_nettype none

module mm_seq #(
   parameter int MAX_DIM = 8,
   parameter int DEPTH   = MAX_DIM * MAX_DIM,
   parameter int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_mode,
   input  wire logic [mm_pkg::DATA_W-1:0]      req_value,
   input  wire logic                           csr_wr_en,
   input  wire logic [mm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mm_pkg::CFG_W-1:0]       csr_wdata,
   input  wire logic                           out_free,
   output logic                                left_wr_en,
   output logic                                right_wr_en,
   output logic [ADDR_W-1:0]                   left_wr_addr,
   output logic [ADDR_W-1:0]                   right_wr_addr,
   output logic [mm_pkg::DATA_W-1:0]           wr_data,
   output logic                                rd_en,
   output logic [ADDR_W-1:0]                   left_rd_addr,
   output logic [ADDR_W-1:0]                   right_rd_addr,
   output mm_pkg::mac_ctl_type                 ctl
);

   import mm_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DIM_W = $clog2(MAX_DIM + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT1,
      ST_WAIT2,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   rows_ff, rows_in;
   logic [CFG_W-1:0]   inner_ff, inner_in;
   logic [CFG_W-1:0]   cols_ff, cols_in;
   logic [CNT_W-1:0]   left_count_ff, left_count_in;
   logic [CNT_W-1:0]   right_count_ff, right_count_in;
   logic [DIM_W-1:0]   i_ff, i_in;
   logic [DIM_W-1:0]   j_ff, j_in;
   logic [DIM_W-1:0]   k_ff, k_in;
   logic [ADDR_W-1:0]  row_base_ff, row_base_in;
   logic [ADDR_W-1:0]  la_ff, la_in;
   logic [ADDR_W-1:0]  ra_ff, ra_in;

   logic [DIM_W-1:0]   m;
   logic [DIM_W-1:0]   n;
   logic [DIM_W-1:0]   p;
   logic [CNT_W-1:0]   need_left;
   logic [CNT_W-1:0]   need_right;
   logic [CNT_W-1:0]   left_next;
   logic [CNT_W-1:0]   right_next;
   logic               accept;
   logic               done_now;
   logic               last_elem;

   // A size register of zero acts as one, a value above the maximum as the maximum.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
      logic [DIM_W-1:0] d;
      if (r == '0) begin
         d = DIM_W'(1);
      end else if (r > CFG_W'(MAX_DIM)) begin
         d = DIM_W'(MAX_DIM);
      end else begin
         d = DIM_W'(r);
      end
      return d;
   endfunction

   assign m = eff_dim(rows_ff);
   assign n = eff_dim(inner_ff);
   assign p = eff_dim(cols_ff);
   assign need_left  = CNT_W'(m) * CNT_W'(n);
   assign need_right = CNT_W'(n) * CNT_W'(p);

   // Requests are taken only between products.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Store writes: a load into a full store is dropped.
   assign left_wr_en    = accept && (req_mode == MODE_LEFT) && (left_count_ff < need_left);
   assign right_wr_en   = accept && (req_mode == MODE_RIGHT) && (right_count_ff < need_right);
   assign left_wr_addr  = left_count_ff[ADDR_W-1:0];
   assign right_wr_addr = right_count_ff[ADDR_W-1:0];
   assign wr_data       = req_value;

   assign left_next  = left_count_ff + CNT_W'(left_wr_en);
   assign right_next = right_count_ff + CNT_W'(right_wr_en);
   assign done_now   = accept && (left_next >= need_left) && (right_next >= need_right);

   assign last_elem = (i_ff == m - DIM_W'(1)) && (j_ff == p - DIM_W'(1));

   // Store reads walk one term of the dot product per cycle.
   assign rd_en         = (state_ff == ST_ISSUE);
   assign left_rd_addr  = la_ff;
   assign right_rd_addr = ra_ff;

   // Next-state logic of the sequencer, the counts and the size registers.
   always_comb begin
      state_in       = state_ff;
      rows_in        = rows_ff;
      inner_in       = inner_ff;
      cols_in        = cols_ff;
      left_count_in  = left_count_ff;
      right_count_in = right_count_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      k_in           = k_ff;
      row_base_in    = row_base_ff;
      la_in          = la_ff;
      ra_in          = ra_ff;
      ctl            = '0;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_ROWS:  rows_in  = csr_wdata;
            CSR_INNER: inner_in = csr_wdata;
            CSR_COLS:  cols_in  = csr_wdata;
            default:   ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (done_now) begin
               // Both stores are full: empty the counts and start the first element.
               left_count_in  = '0;
               right_count_in = '0;
               i_in           = '0;
               j_in           = '0;
               k_in           = '0;
               row_base_in    = '0;
               la_in          = '0;
               ra_in          = '0;
               state_in       = ST_ISSUE;
            end else begin
               left_count_in  = left_next;
               right_count_in = right_next;
            end
         end
         ST_ISSUE: begin
            ctl.issue = 1'b1;
            k_in      = k_ff + DIM_W'(1);
            la_in     = la_ff + ADDR_W'(1);
            ra_in     = ra_ff + ADDR_W'(p);
            if (k_ff == n - DIM_W'(1)) begin
               state_in = ST_WAIT1;
            end
         end
         ST_WAIT1: begin
            state_in = ST_WAIT2;
         end
         ST_WAIT2: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               ctl.emit = 1'b1;
               ctl.last = last_elem;
               k_in     = '0;
               if (last_elem) begin
                  state_in = ST_IDLE;
               end else if (j_ff == p - DIM_W'(1)) begin
                  // Next row of the result.
                  j_in        = '0;
                  i_in        = i_ff + DIM_W'(1);
                  row_base_in = row_base_ff + ADDR_W'(n);
                  la_in       = row_base_ff + ADDR_W'(n);
                  ra_in       = '0;
                  state_in    = ST_ISSUE;
               end else begin
                  j_in     = j_ff + DIM_W'(1);
                  la_in    = row_base_ff;
                  ra_in    = ADDR_W'(j_ff + DIM_W'(1));
                  state_in = ST_ISSUE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, counts, size registers and element indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rows_ff        <= CFG_W'(MAX_DIM);
         inner_ff       <= CFG_W'(MAX_DIM);
         cols_ff        <= CFG_W'(MAX_DIM);
         left_count_ff  <= '0;
         right_count_ff <= '0;
      end else begin
         state_ff       <= state_in;
         rows_ff        <= rows_in;
         inner_ff       <= inner_in;
         cols_ff        <= cols_in;
         left_count_ff  <= left_count_in;
         right_count_ff <= right_count_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      row_base_ff <= row_base_in;
      la_ff       <= la_in;
      ra_ff       <= ra_in;
   end

   // The counts never pass the store depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (left_count_ff <= CNT_W'(DEPTH)) && (right_count_ff <= CNT_W'(DEPTH)))
      else $error("store count beyond depth");

   // A completing request stops further requests until the product is out.
   a_stall_after_done: assert property (@(posedge clock) disable iff (reset)
      done_now |=> req_stall)
      else $error("request accepted during product");

   // While a product is computed both stores count as empty.
   a_counts_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (left_count_ff == '0 && right_count_ff == '0))
      else $error("counts not cleared during product");

endmodule

`default_nettype wire

@@ rtl/core/matrix_multiply.sv @@
// Fixed-point matrix product C = A x B, signed Q4.12.
// Sizes are set through the write port: index 0 rows of A, 1 inner size,
// 2 columns of B; all reset to 8. Write them only while the block is idle.
// Requests carry one element each: req_mode 0 loads the next element of A,
// 1 the next element of B, both in row-major order. A load into a full store
// is dropped. A request is taken every cycle while no product is running.
// The request that leaves both stores full starts the product; req_stall then
// stays high until the last element of C has been placed in the result
// register. Elements of C come out in row-major order with rsp_last on the
// final one and rsp_saturated where the sum was clipped.
// Each element of C is built from one store read per term through the single
// read port of each store, then a multiply into the product register and an
// accumulate, and finally a load of the result register.
// When the receiver holds rsp_stall, the result waits in its register and the
// sequencer waits with the next element. Reset empties both stores and sets
// the sizes to 8; store contents themselves are not cleared.
`default_nettype none

module matrix_multiply #(
   parameter int MAX_DIM   = 8,
   parameter int FRAC_BITS = 12
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_mode,
   input  wire logic signed [mm_pkg::DATA_W-1:0] req_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [mm_pkg::DATA_W-1:0]    rsp_product_value,
   output logic                                rsp_saturated,
   output logic                                rsp_last,
   input  wire logic                           csr_wr_en,
   input  wire logic [mm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mm_pkg::CFG_W-1:0]       csr_wdata
);

   import mm_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic              left_wr_en;
   logic              right_wr_en;
   logic [ADDR_W-1:0] left_wr_addr;
   logic [ADDR_W-1:0] right_wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] left_rd_addr;
   logic [ADDR_W-1:0] right_rd_addr;
   logic [DATA_W-1:0] left_data;
   logic [DATA_W-1:0] right_data;
   logic              out_free;
   mac_ctl_type       ctl;

   // Load handling, size registers and the element sequencer.
   mm_seq #(
      .MAX_DIM (MAX_DIM),
      .DEPTH   (DEPTH),
      .ADDR_W  (ADDR_W)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .out_free      (out_free),
      .left_wr_en    (left_wr_en),
      .right_wr_en   (right_wr_en),
      .left_wr_addr  (left_wr_addr),
      .right_wr_addr (right_wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .left_rd_addr  (left_rd_addr),
      .right_rd_addr (right_rd_addr),
      .ctl           (ctl)
   );

   // Store of the left matrix.
   mm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_left_ram (
      .clock   (clock),
      .wr_en   (left_wr_en),
      .wr_addr (left_wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (left_rd_addr),
      .rd_data (left_data)
   );

   // Store of the right matrix.
   mm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_right_ram (
      .clock   (clock),
      .wr_en   (right_wr_en),
      .wr_addr (right_wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (right_rd_addr),
      .rd_data (right_data)
   );

   // Multiply, accumulate, clip and hold the result.
   mm_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .left_data         (left_data),
      .right_data        (right_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_product_value (rsp_product_value),
      .rsp_saturated     (rsp_saturated),
      .rsp_last          (rsp_last),
      .out_free          (out_free)
   );

endmodule

`default_nettype wire
